/* src/dsml_pkg.sv */
// ----------------------------------------------------------------------------
// dsml_pkg
// Shared types and constants for the DAC sweep minimum lock block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsml_pkg;

  localparam int unsigned CODE_BITS   = 14;
  localparam int unsigned SAMPLE_BITS = 14;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CODE_BITS-1:0] START_RST = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] HIGH_RST  = {CODE_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] LOW_RST   = '0;
  localparam logic [CODE_BITS-1:0] STEP_RST  = CODE_BITS'(64);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START = 2'd0,
    CFG_HIGH  = 2'd1,
    CFG_LOW   = 2'd2,
    CFG_STEP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CODE_BITS-1:0] start;
    logic [CODE_BITS-1:0] high;
    logic [CODE_BITS-1:0] low;
    logic [CODE_BITS-1:0] step;
  } cfg_t;

  typedef struct packed {
    phase_e                        phase;
    logic [CODE_BITS-1:0]          probe;
    logic [CODE_BITS-1:0]          min_code;
    logic signed [SAMPLE_BITS-1:0] best_level;
  } state_t;

endpackage

`default_nettype wire

/* src/dac_sweep_minimum_lock_core.sv */
// ----------------------------------------------------------------------------
// dac_sweep_minimum_lock_core
// Sweeps DAC codes up then down from a start code and locks to the code
// with the lowest measured sample level.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request enters the input register, then its result
//   goes to the result register, where a stall on the output holds it.
// Throughput: one request per cycle unless stalled; the state update is a
//   single compare, add and subtract path between the two registers.
// Reset: asynchronous, active low; clears pipeline valids, sweep state and
//   loads the configuration reset values.
`default_nettype none

module dac_sweep_minimum_lock_core
  import dsml_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [CODE_BITS-1:0]          dac_code_o,
  output logic                          sweep_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CODE_BITS-1:0]          cfg_data_i
);

  cfg_t                          cfg_q;
  state_t                        state_q;
  state_t                        state_d;
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_level_q;
  logic                          out_valid_q;
  logic [CODE_BITS-1:0]          code_q;
  logic                          done_q;
  logic [CODE_BITS-1:0]          code_d;
  logic                          done_d;
  logic                          out_free;
  logic                          s1_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start <= START_RST;
      cfg_q.high  <= HIGH_RST;
      cfg_q.low   <= LOW_RST;
      cfg_q.step  <= STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START: cfg_q.start <= cfg_data_i;
        CFG_HIGH:  cfg_q.high  <= cfg_data_i;
        CFG_LOW:   cfg_q.low   <= cfg_data_i;
        CFG_STEP:  cfg_q.step  <= cfg_data_i;
        default:   cfg_q.step  <= cfg_q.step;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_level_q <= sample_level_i;
    end
  end

  dsml_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .level_i (s1_level_q),
    .state_o (state_d),
    .code_o  (code_d),
    .done_o  (done_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_BASE;
      state_q.probe      <= '0;
      state_q.min_code   <= '0;
      state_q.best_level <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      code_q <= code_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dac_code_o   = code_q;
  assign sweep_done_o = done_q;

  a_done_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sweep_done_o |-> state_q.phase == PH_BASE)
    else $error("done result while sweep still running");

  a_probe_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sweep_done_o |-> state_q.phase != PH_BASE)
    else $error("probe result while sweep idle");

  a_code_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dac_code_o == state_q.probe)
    else $error("output code differs from probe code");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(state_q))
    else $error("sweep state changed without a request");

endmodule

`default_nettype wire

/* src/dsml_step.sv */
// ----------------------------------------------------------------------------
// dsml_step
// Next-state and next-code logic for one sample of the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module dsml_step
  import dsml_pkg::*;
(
  input  state_t                        state_i,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] level_i,
  output state_t                        state_o,
  output logic [CODE_BITS-1:0]          code_o,
  output logic                          done_o
);

  logic                          is_up;
  logic                          is_down;
  logic                          is_base;
  logic                          better;
  logic [CODE_BITS-1:0]          min_code;
  logic signed [SAMPLE_BITS-1:0] best_level;
  logic [CODE_BITS:0]            up_cand;
  logic                          up_ok;
  logic [CODE_BITS-1:0]          dn_src;
  logic [CODE_BITS:0]            dn_cand;
  logic                          dn_ok;

  always_comb begin
    is_up   = 1'b0;
    is_down = 1'b0;
    case (state_i.phase)
      PH_UP:   is_up = 1'b1;
      PH_DOWN: is_down = 1'b1;
      default: is_up = 1'b0;
    endcase
    is_base = !is_up && !is_down;
  end

  assign better     = level_i < state_i.best_level;
  assign min_code   = is_base ? cfg_i.start :
                      (better ? state_i.probe : state_i.min_code);
  assign best_level = (is_base || better) ? level_i : state_i.best_level;

  assign up_cand = is_base ? {1'b0, cfg_i.start}
                           : ({1'b0, state_i.probe} + {1'b0, cfg_i.step});
  assign up_ok   = up_cand < {1'b0, cfg_i.high};

  assign dn_src  = is_down ? state_i.probe : cfg_i.start;
  assign dn_cand = {1'b0, dn_src} - {1'b0, cfg_i.step};
  assign dn_ok   = !dn_cand[CODE_BITS] && (dn_cand[CODE_BITS-1:0] > cfg_i.low);

  always_comb begin
    state_o            = state_i;
    state_o.min_code   = min_code;
    state_o.best_level = best_level;
    if (!is_down && up_ok) begin
      state_o.phase = PH_UP;
      state_o.probe = up_cand[CODE_BITS-1:0];
      done_o        = 1'b0;
    end else if (dn_ok) begin
      state_o.phase = PH_DOWN;
      state_o.probe = dn_cand[CODE_BITS-1:0];
      done_o        = 1'b0;
    end else begin
      state_o.phase = PH_BASE;
      state_o.probe = min_code;
      done_o        = 1'b1;
    end
    code_o = state_o.probe;
  end

endmodule

`default_nettype wire

/* verif/tb_dac_sweep_minimum_lock_core.sv */
// ----------------------------------------------------------------------------
// tb_dac_sweep_minimum_lock_core
// Self-checking bench for the DAC sweep minimum lock core. A queue of sample
// levels feeds a driver with random gaps. A predictor tracks the sweep state
// and the register settings, and yields the expected DAC code and done flag
// for every accepted request. A monitor with random stalls, and one long
// hold-off, checks each result in order against the oldest expected one.
// Register settings change between phases, once all results are back.
// ----------------------------------------------------------------------------

module tb_dac_sweep_minimum_lock_core;
  import dsml_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 150;
  localparam int N_ITEMS    = 700;
  localparam int CODE_MAX   = (1 << CODE_BITS) - 1;
  localparam int LEVEL_MIN  = -(1 << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic [CODE_BITS-1:0] dac_code;
    logic                 sweep_done;
  } lock_result_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_level = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [CODE_BITS-1:0]          dac_code;
  logic                          sweep_done;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index    = CFG_START;
  logic [CODE_BITS-1:0]          cfg_data     = '0;

  logic signed [SAMPLE_BITS-1:0] pending_levels[$];
  lock_result_t                  expected_codes[$];

  cfg_t   sweep_cfg;
  state_t sweep_st;

  int n_queued   = 0;
  int n_samples  = 0;
  int n_codes    = 0;
  int n_locks    = 0;
  int n_writes   = 0;
  int n_settings = 0;
  int n_mismatch = 0;
  int idle_cycles = 0;
  int hold_cnt   = 0;
  logic held_off = 1'b0;
  logic calm;

  assign calm = (n_samples >= 300) && (n_samples < 450);

  always #10 clk = ~clk;

  dac_sweep_minimum_lock_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_level_i (sample_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dac_code_o     (dac_code),
    .sweep_done_o   (sweep_done),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  function automatic lock_result_t sweep_next_code(input logic signed [SAMPLE_BITS-1:0] level);
    lock_result_t         r;
    logic [CODE_BITS:0]   up_code;
    int                   dn_code;
    logic                 go_up;
    logic                 settled;
    go_up   = 1'b1;
    settled = 1'b0;
    up_code = '0;
    dn_code = 0;
    r       = '0;
    if (sweep_st.phase == PH_UP || sweep_st.phase == PH_DOWN) begin
      if (level < $signed(sweep_st.best_level)) begin
        sweep_st.best_level = level;
        sweep_st.min_code   = sweep_st.probe;
      end
    end
    case (sweep_st.phase)
      PH_UP: begin
        up_code = {1'b0, sweep_st.probe} + sweep_cfg.step;
      end
      PH_DOWN: begin
        go_up   = 1'b0;
        dn_code = int'(sweep_st.probe) - int'(sweep_cfg.step);
      end
      default: begin
        sweep_st.best_level = level;
        sweep_st.min_code   = sweep_cfg.start;
        sweep_st.probe      = sweep_cfg.start;
        up_code             = {1'b0, sweep_cfg.start};
      end
    endcase
    if (go_up) begin
      if (up_code < {1'b0, sweep_cfg.high}) begin
        sweep_st.probe = up_code[CODE_BITS-1:0];
        sweep_st.phase = PH_UP;
        r.dac_code     = sweep_st.probe;
        r.sweep_done   = 1'b0;
        settled        = 1'b1;
      end else begin
        dn_code = int'(sweep_cfg.start) - int'(sweep_cfg.step);
      end
    end
    if (!settled) begin
      if (dn_code >= 0 && dn_code > int'(sweep_cfg.low)) begin
        sweep_st.probe = CODE_BITS'(dn_code);
        sweep_st.phase = PH_DOWN;
        r.dac_code     = sweep_st.probe;
        r.sweep_done   = 1'b0;
      end else begin
        sweep_st.probe = sweep_st.min_code;
        sweep_st.phase = PH_BASE;
        r.dac_code     = sweep_st.min_code;
        r.sweep_done   = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_result(input logic [CODE_BITS-1:0] code, input logic done);
    lock_result_t exp_r;
    if (expected_codes.size() == 0) begin
      note_mismatch($sformatf("unexpected result code %0d done %0b", code, done));
    end else begin
      exp_r = expected_codes.pop_front();
      if (code !== exp_r.dac_code) begin
        note_mismatch($sformatf("dac_code expected %0d actual %0d", exp_r.dac_code, code));
      end
      if (done !== exp_r.sweep_done) begin
        note_mismatch($sformatf("sweep_done expected %0b actual %0b (code %0d)",
                                exp_r.sweep_done, done, exp_r.dac_code));
      end
      if (exp_r.sweep_done) begin
        n_locks++;
      end
    end
  endtask

  // sender: hold the request until taken, then advance to the next level
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      sample_level <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_codes.push_back(sweep_next_code(sample_level));
        n_samples++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_levels.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          in_valid     <= 1'b1;
          sample_level <= pending_levels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check, then stall at random or hold off once for a long stretch
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
      held_off  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(dac_code, sweep_done);
        n_codes++;
      end
      if (!held_off && n_samples >= 30) begin
        held_off  <= 1'b1;
        hold_cnt  <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_level(input int lvl);
    pending_levels.push_back(SAMPLE_BITS'(lvl));
    n_queued++;
  endtask

  task automatic drain_results();
    while (n_codes < n_queued) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CODE_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START: sweep_cfg.start = CODE_BITS'(val);
      CFG_HIGH:  sweep_cfg.high  = CODE_BITS'(val);
      CFG_LOW:   sweep_cfg.low   = CODE_BITS'(val);
      default:   sweep_cfg.step  = CODE_BITS'(val);
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int s, input int h, input int l, input int st);
    drain_results();
    write_reg(CFG_START, s);
    write_reg(CFG_HIGH, h);
    write_reg(CFG_LOW, l);
    write_reg(CFG_STEP, st);
    n_settings++;
  endtask

  initial begin
    int kind;
    int s;
    int h;
    int l;
    int st;
    int k_up;
    int k_dn;
    int v;
    int n;
    sweep_cfg           = '{start: START_RST, high: HIGH_RST, low: LOW_RST, step: STEP_RST};
    sweep_st.phase      = PH_BASE;
    sweep_st.probe      = '0;
    sweep_st.min_code   = '0;
    sweep_st.best_level = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: baseline and a first upward probe
    queue_level(0);
    queue_level(-1);
    // upward sum past the code range, start minus step below zero
    configure(16000, CODE_MAX, 0, CODE_MAX);
    queue_level(CODE_MAX >> 1);
    queue_level(LEVEL_MIN);
    queue_level(0);
    queue_level(-1);
    // both sweeps empty: baseline answers at once
    configure(0, 0, 0, 1);
    queue_level(100);
    queue_level(-100);
    configure(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX);
    queue_level(5);
    // zero step stays on the start code until the step changes
    configure(100, 200, 0, 0);
    queue_level(-5);
    queue_level(-5);
    queue_level(-6);
    queue_level(-7);
    drain_results();
    write_reg(CFG_STEP, 50);
    queue_level(-100);
    queue_level(-200);
    queue_level(3);

    while (n_queued < N_ITEMS) begin
      kind = $urandom_range(0, 9);
      s    = $urandom_range(0, CODE_MAX);
      st   = $urandom_range(1, 1500);
      k_up = $urandom_range(0, 10);
      k_dn = $urandom_range(0, 10);
      h    = s + st * k_up + int'($urandom_range(0, st));
      l    = s - st * k_dn - int'($urandom_range(0, st));
      if (kind == 6 || kind == 7) begin
        h  = $urandom_range(0, CODE_MAX);
        l  = $urandom_range(0, CODE_MAX);
        st = $urandom_range(1, CODE_MAX);
      end else if (kind == 8) begin
        v  = $urandom_range(0, 1) ? CODE_MAX : 0;
        s  = v;
        h  = v;
        l  = v;
        st = v;
      end else if (kind == 9) begin
        st = 1;
        h  = s + int'($urandom_range(0, 6));
        l  = s - int'($urandom_range(0, 6));
      end
      if (h > CODE_MAX) h = CODE_MAX;
      if (l < 0) l = 0;
      configure(s, h, l, st);
      n = $urandom_range(40, 80);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_level(int'($urandom_range(0, 8)) - 4);
        end else begin
          queue_level(int'($urandom_range(0, CODE_MAX)) + LEVEL_MIN);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    if (expected_codes.size() != 0) begin
      $display("%0d expected codes never arrived", expected_codes.size());
    end
    $display("Swept %0d samples over %0d register settings (%0d writes)",
             n_samples, n_settings, n_writes);
    $display("Checked %0d codes, %0d locked sweeps, %0d mismatches",
             n_codes, n_locks, n_mismatch);
    if (n_mismatch == 0 && expected_codes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dsml_pkg.sv
src/dsml_step.sv
src/dac_sweep_minimum_lock_core.sv
verif/tb_dac_sweep_minimum_lock_core.sv
